// ----- rtl/i2cbl_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbl_pkg: shared codes for the i2c bit-level master
// item kinds, operation codes, sequencer phases and the send-slot decode
// ----------------------------------------------------------------------------
package i2cbl_pkg;

  // item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // operation codes
  localparam logic [1:0] OP_WR1  = 2'd0;
  localparam logic [1:0] OP_WR2  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_SEND  = 3'd2;
  localparam logic [2:0] PH_READ  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  // step counts that close each phase
  localparam logic [4:0] START_LAST = 5'd3;
  localparam logic [4:0] SEND_DATA_LAST = 5'd24;
  localparam logic [4:0] SEND_ACK_HIGH = 5'd26;
  localparam logic [4:0] SEND_LAST = 5'd27;
  localparam logic [4:0] READ_DATA_LAST = 5'd16;
  localparam logic [4:0] READ_NACK_HIGH = 5'd18;
  localparam logic [4:0] READ_LAST = 5'd19;
  localparam logic [4:0] STOP_LAST = 5'd2;

  // byte counts loaded by a command (address byte included)
  localparam logic [1:0] NBYTES_WR1  = 2'd2;
  localparam logic [1:0] NBYTES_WR2  = 2'd3;
  localparam logic [1:0] NBYTES_READ = 2'd1;

  localparam logic [1:0] LINES_HIGH = 2'b11;

  typedef struct packed {
    logic [2:0] bidx;  // bit index within the byte, msb first
    logic [1:0] sub;   // 0 low, 1 high, 2 low
  } send_slot_t;

  // step 1..24 -> bit and sub-step; divide by three via multiply by 11 / 32
  function automatic send_slot_t send_slot(input logic [4:0] step);
    logic [4:0] t;
    logic [8:0] prod;
    logic [2:0] q;
    logic [4:0] q3;
    send_slot_t r;
    t    = step - 5'd1;
    prod = {4'd0, t} * 9'd11;
    q    = prod[7:5];
    q3   = {1'b0, q, 1'b0} + {2'd0, q};
    r.bidx = 3'd7 - q;
    r.sub  = 2'(t - q3);
    return r;
  endfunction

endpackage

// ----- rtl/i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master: bit-bang i2c master sequencer
// one item per clock while no result is stalled, each tick item steps scl/sda one level pair
// ----------------------------------------------------------------------------
// an accepted item gives its registered result item in the next cycle
// throughput: one item per clock; the only limit is the result register,
//   in_stall rises only while a held result is stalled by the receiver
// reset: synchronous, active low; sequencer idle, both lines released,
//   read byte and ack error cleared, no result pending
module i2c_bit_level_master
  import i2cbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_target_address,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [1:0] in_lines_in,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_ack_error
);

  // sequencer state
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  logic [1:0]  lines_r, lines_nxt;   // bit0 scl, bit1 sda
  logic        ack_r, ack_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        scl_r, sda_r, busy_r, done_r, ack_out_r;
  logic [7:0]  rd_out_r;

  logic        in_acc;
  logic        out_load;
  logic        done_nxt;
  logic [1:0]  left_dec;
  logic [4:0]  rd_t;
  send_slot_t  slot;

  // result register frees up when empty or taken this cycle
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign slot = send_slot(step_r);
  assign rd_t = step_r - 5'd1;

  always_comb begin
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    bytes_left_nxt = bytes_left_r;
    shift_nxt      = shift_r;
    pending_nxt    = pending_r;
    op_nxt         = op_r;
    rdata_nxt      = rdata_r;
    lines_nxt      = lines_r;
    ack_nxt        = ack_r;
    done_nxt       = 1'b0;
    left_dec       = bytes_left_r;

    if (in_acc) begin
      if (in_kind == KIND_CMD) begin
        // new command only from idle, unused op code ignored
        if (phase_r == PH_IDLE && in_operation != OP_NONE) begin
          op_nxt    = in_operation;
          step_nxt  = 5'd0;
          phase_nxt = PH_START;
          case (in_operation)
            OP_WR1: begin
              shift_nxt      = {in_target_address[6:0], 1'b0};
              pending_nxt    = {8'd0, in_first_byte};
              bytes_left_nxt = NBYTES_WR1;
            end
            OP_WR2: begin
              shift_nxt      = in_target_address;
              pending_nxt    = {in_second_byte, in_first_byte};
              bytes_left_nxt = NBYTES_WR2;
            end
            default: begin
              shift_nxt      = in_target_address;
              pending_nxt    = 16'd0;
              bytes_left_nxt = NBYTES_READ;
            end
          endcase
        end
      end else if (phase_r != PH_IDLE) begin
        case (phase_r)
          PH_START: begin
            // sda falls while scl high, then scl low
            case (step_r[1:0])
              2'd0:    lines_nxt = 2'b10;
              2'd1:    lines_nxt = 2'b11;
              2'd2:    lines_nxt = 2'b01;
              default: lines_nxt = 2'b00;
            endcase
            if (step_r >= START_LAST) begin
              phase_nxt = PH_SEND;
              step_nxt  = 5'd0;
            end else begin
              step_nxt = step_r + 5'd1;
            end
          end

          PH_SEND: begin
            if (step_r == 5'd0) begin
              lines_nxt = 2'b00;
            end else if (step_r <= SEND_DATA_LAST) begin
              lines_nxt = {shift_r[slot.bidx], slot.sub == 2'd1};
            end else if (step_r == SEND_ACK_HIGH) begin
              // ack slot: both lines high means nobody pulled sda low
              lines_nxt = 2'b11;
              ack_nxt   = (in_lines_in == LINES_HIGH);
            end else begin
              lines_nxt = 2'b10;
            end
            if (step_r >= SEND_LAST) begin
              step_nxt = 5'd0;
              if (bytes_left_r != 2'd0) begin
                left_dec = bytes_left_r - 2'd1;
              end
              bytes_left_nxt = left_dec;
              if (left_dec != 2'd0) begin
                shift_nxt   = pending_r[7:0];
                pending_nxt = {8'd0, pending_r[15:8]};
              end else if (op_r == OP_READ) begin
                phase_nxt = PH_READ;
                shift_nxt = 8'd0;
              end else begin
                phase_nxt = PH_STOP;
              end
            end else begin
              step_nxt = step_r + 5'd1;
            end
          end

          PH_READ: begin
            if (step_r >= 5'd1 && step_r <= READ_DATA_LAST && !rd_t[0]) begin
              // scl high on a data bit, sample sda msb first
              lines_nxt = 2'b11;
              if (in_lines_in[1]) begin
                shift_nxt = shift_r | (8'd1 << (3'd7 - rd_t[3:1]));
              end
            end else if (step_r == READ_NACK_HIGH) begin
              lines_nxt = 2'b11;
            end else begin
              lines_nxt = 2'b10;
            end
            if (step_r >= READ_LAST) begin
              rdata_nxt = shift_r;
              phase_nxt = PH_STOP;
              step_nxt  = 5'd0;
            end else begin
              step_nxt = step_r + 5'd1;
            end
          end

          PH_STOP: begin
            // sda rises while scl high
            if (step_r == 5'd0) begin
              lines_nxt = 2'b00;
            end else if (step_r == 5'd1) begin
              lines_nxt = 2'b01;
            end else begin
              lines_nxt = 2'b11;
            end
            if (step_r >= STOP_LAST) begin
              phase_nxt = PH_IDLE;
              step_nxt  = 5'd0;
              done_nxt  = 1'b1;
            end else begin
              step_nxt = step_r + 5'd1;
            end
          end

          default: begin
            phase_nxt = PH_IDLE;
            step_nxt  = 5'd0;
          end
        endcase
      end
    end
  end

  // result register keeps its item while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      step_r       <= 5'd0;
      bytes_left_r <= 2'd0;
      shift_r      <= 8'd0;
      pending_r    <= 16'd0;
      op_r         <= OP_WR1;
      rdata_r      <= 8'd0;
      lines_r      <= LINES_HIGH;
      ack_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      bytes_left_r <= bytes_left_nxt;
      shift_r      <= shift_nxt;
      pending_r    <= pending_nxt;
      op_r         <= op_nxt;
      rdata_r      <= rdata_nxt;
      lines_r      <= lines_nxt;
      ack_r        <= ack_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load && in_acc) begin
      scl_r     <= lines_nxt[0];
      sda_r     <= lines_nxt[1];
      busy_r    <= (phase_nxt != PH_IDLE);
      done_r    <= done_nxt;
      rd_out_r  <= rdata_nxt;
      ack_out_r <= ack_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = scl_r;
  assign out_sda_out   = sda_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_data = rd_out_r;
  assign out_ack_error = ack_out_r;

endmodule

// ----- rtl/i2cbl_checker.sv -----
// ----------------------------------------------------------------------------
// i2cbl_checker: port-level checks for the i2c bit-level master
// watches the handshakes and the bus levels shown in result items
// ----------------------------------------------------------------------------
module i2cbl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_scl_out,
  input logic       out_sda_out,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_data,
  input logic       out_ack_error
);

  // a finished stop leaves the bus released and the master idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && out_scl_out && out_sda_out)
    else $error("done item without idle released bus");

  // an idle master never holds a line low
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_out && out_sda_out)
    else $error("idle master drives a line low");

  // input is held back only by a stalled pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // every accepted item shows up as a result item in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result item");

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl_out) &&
      $stable(out_sda_out) && $stable(out_busy_res) && $stable(out_done_res) &&
      $stable(out_read_data) && $stable(out_ack_error))
    else $error("stalled result changed");

endmodule

bind i2c_bit_level_master i2cbl_checker u_i2cbl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_scl_out   (out_scl_out),
  .out_sda_out   (out_sda_out),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_data (out_read_data),
  .out_ack_error (out_ack_error)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the i2c bit-level master
// drives command and tick items through the input channel, keeps its own
// bit-step model of the start/send/read/stop sequencer and compares every
// result item field by field, with random idle bursts on both channels
// ----------------------------------------------------------------------------
module tb_top;
  import i2cbl_pkg::*;

  localparam int RANDOM_ITEMS  = 700;   // least items in the whole run, directed ones included
  localparam int TAIL_ITEMS    = 80;    // no idling once this few are left
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 4;     // covers the result register plus margin

  // one input item as seen on the pins, plus a hold-off request
  typedef struct {
    logic       kind;
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] lines;
    bit         drain;  // hold this item back until every result is in
  } bus_item_t;

  // one result item
  typedef struct {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       ack_err;
  } bus_result_t;

  // how the sampled bus lines look during a transaction
  typedef enum {LINES_ANY, LINES_OPEN, LINES_PULLED, LINES_MOSTLY_OPEN} line_bias_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_kind = KIND_TICK;
  logic [1:0] in_operation = OP_WR1;
  logic [7:0] in_target_address = 8'h00;
  logic [7:0] in_first_byte = 8'h00;
  logic [7:0] in_second_byte = 8'h00;
  logic [1:0] in_lines_in = LINES_HIGH;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_read_data;
  logic       out_ack_error;

  bus_item_t   items_to_send[$];  // stimulus not yet on the pins
  bus_result_t levels_due[$];     // predicted results, oldest first

  int          mismatches = 0;
  int          items_in = 0;      // accepted input items
  int          items_out = 0;     // accepted result items
  int          send_gap = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int unsigned cycle_count = 0;
  logic        tail_run = 1'b0;
  logic        idling_on;

  // model state of the sequencer
  logic [2:0]  m_phase = PH_IDLE;
  logic [4:0]  m_step = '0;
  logic [1:0]  m_left = '0;
  logic [7:0]  m_shift = '0;
  logic [15:0] m_pending = '0;
  logic [1:0]  m_op = OP_WR1;
  logic [7:0]  m_rbyte = '0;
  logic [1:0]  m_lines = LINES_HIGH;  // bit0 scl, bit1 sda
  logic        m_ack = 1'b0;

  always #1 clk = ~clk;

  i2c_bit_level_master uut (.*);

  // idling is allowed most of the time, with a recurring calm stretch
  assign idling_on = (cycle_count % 512) < 448;

  // --------------------------------------------------------------------------
  // sequencer model: apply one item, return the result it produces
  // --------------------------------------------------------------------------
  function automatic bus_result_t step_bus_model(input bus_item_t it);
    bus_result_t r;
    int          s;
    int          bit_idx;
    int          sub;
    logic        fin;
    fin = 1'b0;
    s   = m_step;
    if (it.kind == KIND_CMD) begin
      // commands only start from idle; the unused code is dropped
      if (m_phase == PH_IDLE && it.op != OP_NONE) begin
        m_op    = it.op;
        m_step  = '0;
        m_phase = PH_START;
        case (it.op)
          OP_WR1: begin
            m_shift   = {it.addr[6:0], 1'b0};
            m_pending = {8'h00, it.b1};
            m_left    = NBYTES_WR1;
          end
          OP_WR2: begin
            m_shift   = it.addr;
            m_pending = {it.b2, it.b1};
            m_left    = NBYTES_WR2;
          end
          default: begin
            m_shift   = it.addr;
            m_pending = '0;
            m_left    = NBYTES_READ;
          end
        endcase
      end
    end else begin
      case (m_phase)
        PH_IDLE: ;  // tick with nothing to do
        PH_START: begin
          // sda falls while scl is high
          case (s % 4)
            0: m_lines = 2'b10;
            1: m_lines = 2'b11;
            2: m_lines = 2'b01;
            default: m_lines = 2'b00;
          endcase
          if (s >= 3) begin
            m_phase = PH_SEND;
            m_step  = '0;
          end else begin
            m_step = 5'(s + 1);
          end
        end
        PH_SEND: begin
          if (s == 0) begin
            m_lines = 2'b00;
          end else if (s <= 24) begin
            // three steps per bit, msb first: low, high, low
            bit_idx = 7 - (s - 1) / 3;
            sub     = (s - 1) % 3;
            m_lines = {m_shift[bit_idx], sub == 1};
          end else if (s == 26) begin
            // ack slot: no answer if both lines read high
            m_lines = 2'b11;
            m_ack   = (it.lines == LINES_HIGH);
          end else begin
            m_lines = 2'b10;
          end
          if (s >= 27) begin
            m_step = '0;
            if (m_left > 0) m_left = m_left - 1'b1;
            if (m_left > 0) begin
              m_shift   = m_pending[7:0];
              m_pending = m_pending >> 8;
            end else if (m_op == OP_READ) begin
              m_phase = PH_READ;
              m_shift = '0;
            end else begin
              m_phase = PH_STOP;
            end
          end else begin
            m_step = 5'(s + 1);
          end
        end
        PH_READ: begin
          if (s >= 1 && s <= 16 && ((s - 1) % 2) == 0) begin
            // scl high: sample sda into the next bit
            bit_idx = 7 - (s - 1) / 2;
            m_lines = 2'b11;
            if (it.lines[1]) m_shift[bit_idx] = 1'b1;
          end else if (s == 18) begin
            m_lines = 2'b11;  // master nack
          end else begin
            m_lines = 2'b10;
          end
          if (s >= 19) begin
            m_rbyte = m_shift;
            m_phase = PH_STOP;
            m_step  = '0;
          end else begin
            m_step = 5'(s + 1);
          end
        end
        PH_STOP: begin
          if (s == 0) m_lines = 2'b00;
          else if (s == 1) m_lines = 2'b01;
          else m_lines = 2'b11;
          if (s >= 2) begin
            m_phase = PH_IDLE;
            m_step  = '0;
            fin     = 1'b1;
          end else begin
            m_step = 5'(s + 1);
          end
        end
        default: begin
          m_phase = PH_IDLE;
          m_step  = '0;
        end
      endcase
    end
    r.scl     = m_lines[0];
    r.sda     = m_lines[1];
    r.busy    = (m_phase != PH_IDLE);
    r.done    = fin;
    r.rdata   = m_rbyte;
    r.ack_err = m_ack;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bus_item_t random_item();
    bus_item_t it;
    it.kind  = 1'($urandom_range(0, 1));
    it.op    = 2'($urandom_range(0, 3));
    it.addr  = 8'($urandom);
    it.b1    = 8'($urandom);
    it.b2    = 8'($urandom);
    it.lines = 2'($urandom_range(0, 3));
    it.drain = 1'b0;
    return it;
  endfunction

  // a command followed by exactly the ticks that carry it to its stop;
  // noise_at places an extra command among the ticks (ignored while busy)
  task automatic queue_transaction(input logic [1:0] op, input logic [7:0] addr,
                                   input logic [7:0] b1, input logic [7:0] b2,
                                   input line_bias_t bias, input bit drain,
                                   input int noise_at);
    bus_item_t it;
    int        n_bytes;
    int        n_ticks;
    it       = random_item();
    it.kind  = KIND_CMD;
    it.op    = op;
    it.addr  = addr;
    it.b1    = b1;
    it.b2    = b2;
    it.drain = drain;
    items_to_send.push_back(it);
    n_bytes = (op == OP_WR2) ? 3 : (op == OP_WR1) ? 2 : 1;
    // start 4, 28 per byte sent, 20 for the read byte, stop 3
    n_ticks = 7 + 28 * n_bytes + ((op == OP_READ) ? 20 : 0);
    for (int i = 0; i < n_ticks; i++) begin
      if (i == noise_at) begin
        it      = random_item();
        it.kind = KIND_CMD;
        items_to_send.push_back(it);
      end
      it      = random_item();
      it.kind = KIND_TICK;
      case (bias)
        LINES_OPEN:        it.lines = LINES_HIGH;
        LINES_PULLED:      it.lines = 2'b00;
        LINES_MOSTLY_OPEN: if ($urandom_range(0, 9) != 0) it.lines = LINES_HIGH;
        default: ;
      endcase
      items_to_send.push_back(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: one item per handshake, held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    bus_item_t acc;
    bus_item_t nxt;
    int        waiting;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      waiting = items_in - items_out;
      if (in_valid) begin
        // the item on the pins was just taken: predict its result
        acc.kind  = in_kind;
        acc.op    = in_operation;
        acc.addr  = in_target_address;
        acc.b1    = in_first_byte;
        acc.b2    = in_second_byte;
        acc.lines = in_lines_in;
        acc.drain = 1'b0;
        levels_due.push_back(step_bus_model(acc));
        items_in <= items_in + 1;
        waiting++;
      end
      tail_run <= (items_to_send.size() < TAIL_ITEMS);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!tail_run && idling_on && $urandom_range(0, 7) == 0) begin
        // idle burst, its length drawn at random into send_gap
        send_gap = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0 &&
                   !(items_to_send[0].drain && waiting != 0)) begin
        nxt = items_to_send.pop_front();
        in_valid          <= 1'b1;
        in_kind           <= nxt.kind;
        in_operation      <= nxt.op;
        in_target_address <= nxt.addr;
        in_first_byte     <= nxt.b1;
        in_second_byte    <= nxt.b2;
        in_lines_in       <= nxt.lines;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compare each result with the oldest prediction, random stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    bus_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        items_out <= items_out + 1;
        if (levels_due.size() == 0) begin
          $error("result item with no item waiting for it");
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (out_scl_out !== want.scl) begin
            $error("scl_out: expected %0d, got %0d", want.scl, out_scl_out);
            mismatches++;
          end
          if (out_sda_out !== want.sda) begin
            $error("sda_out: expected %0d, got %0d", want.sda, out_sda_out);
            mismatches++;
          end
          if (out_busy_res !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, out_busy_res);
            mismatches++;
          end
          if (out_done_res !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, out_done_res);
            mismatches++;
          end
          if (out_read_data !== want.rdata) begin
            $error("read_data: expected %02h, got %02h", want.rdata, out_read_data);
            mismatches++;
          end
          if (out_ack_error !== want.ack_err) begin
            $error("ack_error: expected %0d, got %0d", want.ack_err, out_ack_error);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!tail_run && idling_on && $urandom_range(0, 7) == 0) begin
        // stall burst, its length drawn at random into stall_left
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run_control
    bus_item_t  it;
    int         goal;
    int         n_noise;
    logic [1:0] op;

    // tick while idle, then the unused operation code
    it      = random_item();
    it.kind = KIND_TICK;
    items_to_send.push_back(it);
    it      = random_item();
    it.kind = KIND_CMD;
    it.op   = OP_NONE;
    it.addr = 8'hFF;
    items_to_send.push_back(it);

    // write-one, address msb dropped, no device answering, with a
    // command landing in the middle that must be ignored
    queue_transaction(OP_WR1, 8'hFF, 8'h00, 8'hFF, LINES_OPEN, 1'b0, 5);
    // write-two with every ack pulled low: ack error clears
    queue_transaction(OP_WR2, 8'h00, 8'hFF, 8'hA5, LINES_PULLED, 1'b0, -1);
    // reads of all ones and all zeros; the first waits for an empty pipe
    queue_transaction(OP_READ, 8'hFF, 8'h00, 8'h00, LINES_OPEN, 1'b1, -1);
    queue_transaction(OP_READ, 8'h5A, 8'h00, 8'h00, LINES_PULLED, 1'b0, 30);

    // random part: mostly complete transactions, some loose noise items
    goal = RANDOM_ITEMS;
    while (items_to_send.size() < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        // loose items: may start a transaction that never gets its ticks
        n_noise = $urandom_range(1, 5);
        repeat (n_noise) items_to_send.push_back(random_item());
      end else begin
        op = 2'($urandom_range(0, 2));
        queue_transaction(op, 8'($urandom), 8'($urandom), 8'($urandom),
                          line_bias_t'($urandom_range(0, 3)),
                          $urandom_range(0, 11) == 0,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : -1);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to go in and every result to come out
    while (items_to_send.size() != 0 || in_valid || items_in != items_out)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (levels_due.size() != 0) begin
      $error("%0d expected result items never arrived", levels_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- i2c_bit_level_master.f -----
rtl/i2cbl_pkg.sv
rtl/i2c_bit_level_master.sv
rtl/i2cbl_checker.sv
tb/tb_top.sv
